/* design/bhr_pkg.sv */
// Shared types, codes and constants of the box height rasterizer.
package bhr_pkg;

	localparam int GRID_RES_DEF = 64;
	localparam int COORD_W = 24;
	localparam int DIFF_W = COORD_W + 1;
	localparam int HEIGHT_W = 16;
	localparam int CELL_IDX_W = 12;
	localparam int REQ_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W = $clog2(QUEUE_DEPTH);

	localparam logic [REQ_W-1:0] REQ_DRAW = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Z = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0] diff_t;

	typedef struct packed {
		coord_t min_x;
		coord_t min_z;
		coord_t max_x;
		coord_t max_z;
	} region_t;

	// Queued command; box corners are already taken relative to the region minimum.
	typedef struct packed {
		logic [REQ_W-1:0] kind;
		diff_t dx0;
		diff_t dz0;
		diff_t dx1;
		diff_t dz1;
		logic [HEIGHT_W-1:0] height;
		logic [CELL_IDX_W-1:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic ceil_mode;
		diff_t numer;
		logic [DIFF_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_rsp_t;

endpackage

/* design/bhr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bhr_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* design/bhr_div.sv */
// Serial scaler and divider that maps one box coordinate to a clamped cell index.
module bhr_div #(
	parameter int GRID_RES = bhr_pkg::GRID_RES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bhr_pkg::div_req_t              req,
	output bhr_pkg::div_rsp_t              rsp,
	output logic [$clog2(GRID_RES)-1:0]    idx
);

	localparam int IDX_W = $clog2(GRID_RES);
	localparam int MUL_W = bhr_pkg::DIFF_W + IDX_W + 1;
	localparam int MAG_W = MUL_W - 1;
	localparam int DEN_W = bhr_pkg::DIFF_W;
	localparam int CNT_W = $clog2(MAG_W);
	localparam logic signed [MUL_W-1:0] SCALE = MUL_W'(GRID_RES - 1);
	localparam logic [MAG_W:0] IDX_MAX = (MAG_W + 1)'(GRID_RES - 1);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_CHECK = 2'd1;
	localparam logic [1:0] D_RUN = 2'd2;
	localparam logic [1:0] D_FIX = 2'd3;

	logic [1:0] state_q;
	logic signed [MUL_W-1:0] prod_q;
	logic signed [MUL_W-1:0] numer_ext;
	logic [DEN_W-1:0] den_q;
	logic ceil_q;
	logic [MAG_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic [IDX_W-1:0] idx_q;
	logic [DEN_W:0] rem_next;
	logic ge;
	logic [MAG_W:0] sum;

	assign numer_ext = MUL_W'(req.numer);
	assign rem_next = {rem_q, quot_q[MAG_W-1]};
	assign ge = rem_next >= {1'b0, den_q};
	assign sum = {1'b0, quot_q} + (MAG_W + 1)'(ceil_q && (rem_q != '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					// A negative numerator always lands below the grid and clamps to zero.
					if (prod_q[MUL_W-1]) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (cnt_q == '0) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (req.start) begin
					prod_q <= numer_ext * SCALE;
					den_q <= req.denom;
					ceil_q <= req.ceil_mode;
				end
			end
			D_CHECK: begin
				quot_q <= prod_q[MAG_W-1:0];
				rem_q <= '0;
				cnt_q <= CNT_W'(MAG_W - 1);
				idx_q <= '0;
			end
			D_RUN: begin
				rem_q <= ge ? DEN_W'(rem_next - {1'b0, den_q}) : rem_next[DEN_W-1:0];
				quot_q <= {quot_q[MAG_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			D_FIX: begin
				idx_q <= (sum > IDX_MAX) ? IDX_W'(GRID_RES - 1) : sum[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	assign rsp.busy = state_q != D_IDLE;
	assign rsp.done = done_q;
	assign idx = idx_q;

endmodule

/* design/bhr_front.sv */
// Request intake: decodes and screens requests and queues them for the back end.
module bhr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [127:0]              s_axis_tdata,
	input  logic [bhr_pkg::REQ_W-1:0] s_axis_tuser,
	input  bhr_pkg::region_t          region,
	input  logic                      hold,
	input  logic                      pop,
	output logic                      empty,
	output bhr_pkg::cmd_t             head
);

	bhr_pkg::cmd_t q_mem_q [bhr_pkg::QUEUE_DEPTH];
	logic [bhr_pkg::QP_W-1:0] wr_ptr_q;
	logic [bhr_pkg::QP_W-1:0] rd_ptr_q;
	logic [bhr_pkg::QP_W:0] count_q;
	logic full;
	logic accept;
	logic keep;
	logic push;
	logic draw_hit;
	bhr_pkg::coord_t bx0, bz0, bx1, bz1;
	bhr_pkg::cmd_t cmd;

	assign bx0 = s_axis_tdata[23:0];
	assign bz0 = s_axis_tdata[47:24];
	assign bx1 = s_axis_tdata[71:48];
	assign bz1 = s_axis_tdata[95:72];

	// A draw that misses the region, or hits an empty region, is dropped here.
	assign draw_hit = (region.max_x > region.min_x) && (region.max_z > region.min_z)
		&& !(bx0 > region.max_x) && !(bx1 < region.min_x)
		&& !(bz0 > region.max_z) && !(bz1 < region.min_z);

	always_comb begin
		case (s_axis_tuser)
			bhr_pkg::REQ_DRAW: keep = draw_hit;
			bhr_pkg::REQ_READ: keep = 1'b1;
			bhr_pkg::REQ_CLEAR: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	always_comb begin
		cmd.kind = s_axis_tuser;
		cmd.dx0 = {bx0[23], bx0} - {region.min_x[23], region.min_x};
		cmd.dz0 = {bz0[23], bz0} - {region.min_z[23], region.min_z};
		cmd.dx1 = {bx1[23], bx1} - {region.min_x[23], region.min_x};
		cmd.dz1 = {bz1[23], bz1} - {region.min_z[23], region.min_z};
		cmd.height = s_axis_tdata[111:96];
		cmd.cell_index = s_axis_tdata[123:112];
	end

	assign full = count_q == (bhr_pkg::QP_W + 1)'(bhr_pkg::QUEUE_DEPTH);
	assign s_axis_tready = !full && !hold;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign push = accept && keep;
	assign empty = count_q == '0;
	assign head = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bhr_pkg::QP_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bhr_pkg::QP_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (bhr_pkg::QP_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (bhr_pkg::QP_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cmd;
		end
	end

endmodule

/* design/bhr_back.sv */
// Command execution: index mapping, cell fill, grid sweeps and cell reads.
module bhr_back #(
	parameter int GRID_RES = bhr_pkg::GRID_RES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bhr_pkg::region_t             region,
	input  logic                         empty,
	input  bhr_pkg::cmd_t                head,
	output logic                         pop,
	output logic                         hold,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [bhr_pkg::HEIGHT_W-1:0] m_axis_tdata,
	output logic                         m_axis_tuser
);

	localparam int IDX_W = $clog2(GRID_RES);
	localparam int CELL_COUNT = GRID_RES * GRID_RES;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int WORD_W = bhr_pkg::HEIGHT_W + 1;

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_READ_WAIT = 3'd3;
	localparam logic [2:0] ST_DIV = 3'd4;
	localparam logic [2:0] ST_DIV_WAIT = 3'd5;
	localparam logic [2:0] ST_SETUP = 3'd6;
	localparam logic [2:0] ST_FILL = 3'd7;

	logic [2:0] state_q;
	logic init_q;
	bhr_pkg::cmd_t cur_q;
	logic [AW-1:0] sweep_addr_q;
	logic [1:0] div_k_q;
	logic [IDX_W-1:0] ilo_q, ihi_q, jlo_q, jhi_q, col_q, row_q;
	logic [AW-1:0] row_base_q;
	logic out_valid_q;
	logic [bhr_pkg::HEIGHT_W-1:0] out_height_q;
	logic out_tex_q;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;
	logic in_range;
	logic out_free;
	logic [IDX_W-1:0] imin, jmin;
	logic [bhr_pkg::DIFF_W-1:0] span_x, span_z;
	bhr_pkg::div_req_t div_req;
	bhr_pkg::div_rsp_t div_rsp;
	logic [IDX_W-1:0] div_idx;

	assign span_x = {region.max_x[23], region.max_x} - {region.min_x[23], region.min_x};
	assign span_z = {region.max_z[23], region.max_z} - {region.min_z[23], region.min_z};

	always_comb begin
		div_req.start = state_q == ST_DIV;
		div_req.ceil_mode = !div_k_q[0];
		div_req.denom = div_k_q[1] ? span_z : span_x;
		case (div_k_q)
			2'd0: div_req.numer = cur_q.dx0;
			2'd1: div_req.numer = cur_q.dx1;
			2'd2: div_req.numer = cur_q.dz0;
			default: div_req.numer = cur_q.dz1;
		endcase
	end

	bhr_div #(
		.GRID_RES(GRID_RES)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp),
		.idx(div_idx)
	);

	assign in_range = 17'(cur_q.cell_index) < 17'(CELL_COUNT);
	assign out_free = !out_valid_q || m_axis_tready;
	assign imin = (ilo_q < ihi_q) ? ilo_q : ihi_q;
	assign jmin = (jlo_q < jhi_q) ? jlo_q : jhi_q;
	assign pop = (state_q == ST_IDLE) && !empty;
	assign hold = init_q;

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = sweep_addr_q;
		mem_wdata = '0;
		if (state_q == ST_SWEEP) begin
			mem_we = 1'b1;
		end else if (state_q == ST_FILL) begin
			mem_we = 1'b1;
			mem_waddr = row_base_q + AW'(col_q);
			mem_wdata = {1'b1, cur_q.height};
		end
	end

	bhr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(CELL_COUNT)
	) u_grid (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(AW'(cur_q.cell_index)),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			init_q <= 1'b1;
			sweep_addr_q <= '0;
			div_k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_addr_q == AW'(CELL_COUNT - 1)) begin
						init_q <= 1'b0;
						state_q <= ST_IDLE;
					end
					sweep_addr_q <= sweep_addr_q + AW'(1);
				end
				ST_IDLE: begin
					if (!empty) begin
						case (head.kind)
							bhr_pkg::REQ_DRAW: begin
								div_k_q <= '0;
								state_q <= ST_DIV;
							end
							bhr_pkg::REQ_READ: state_q <= ST_READ;
							bhr_pkg::REQ_CLEAR: begin
								sweep_addr_q <= '0;
								state_q <= ST_SWEEP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					// The read is issued only when the output register will be free.
					if (out_free) begin
						state_q <= ST_READ_WAIT;
					end
				end
				ST_READ_WAIT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DIV: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						div_k_q <= div_k_q + 2'd1;
						state_q <= (div_k_q == 2'd3) ? ST_SETUP : ST_DIV;
					end
				end
				ST_SETUP: state_q <= ST_FILL;
				ST_FILL: begin
					if (col_q == ihi_q && row_q == jhi_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == ST_READ_WAIT) begin
			if (in_range && mem_rdata[WORD_W-1]) begin
				out_height_q <= mem_rdata[bhr_pkg::HEIGHT_W-1:0];
				out_tex_q <= 1'b0;
			end else begin
				out_height_q <= '0;
				out_tex_q <= 1'b1;
			end
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			case (div_k_q)
				2'd0: ilo_q <= div_idx;
				2'd1: ihi_q <= div_idx;
				2'd2: jlo_q <= div_idx;
				default: jhi_q <= div_idx;
			endcase
		end
		if (state_q == ST_SETUP) begin
			ilo_q <= imin;
			col_q <= imin;
			row_q <= jmin;
			row_base_q <= AW'(jmin) * AW'(GRID_RES);
		end
		if (state_q == ST_FILL) begin
			if (col_q == ihi_q) begin
				col_q <= ilo_q;
				row_q <= row_q + IDX_W'(1);
				row_base_q <= row_base_q + AW'(GRID_RES);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_height_q;
	assign m_axis_tuser = out_tex_q;

`ifndef ASSERT_OFF
	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !out_valid_q)
		else $error("result presented during the initial grid sweep");
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ_WAIT |-> !out_valid_q || m_axis_tready)
		else $error("read data would overwrite a pending result");
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");
	a_fill_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> col_q <= ihi_q && row_q <= jhi_q)
		else $error("fill walked outside the box rectangle");
`endif

endmodule

/* design/box_height_rasterizer_unit.sv */
// Top level of the box height rasterizer: configuration registers, intake and execution.
//
// The block keeps a GRID_RES x GRID_RES grid of 16-bit heights over the XZ region set in
// the four region registers. Requests arrive on the slave stream with the request kind in
// tuser; read requests return one transaction on the master stream, while draws and clears
// return nothing. Requests wait in a four-entry queue and are carried out one at a time.
// A draw runs four index mappings through one shared serial divider and then writes one
// grid cell per cycle over the covered cells. A clear rewrites every cell of the grid
// memory. After reset the same sweep runs once, and no request is accepted until it
// ends; configuration writes are taken at any time.
module box_height_rasterizer_unit #(
	parameter int GRID_RES = bhr_pkg::GRID_RES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// box_min_x, box_min_z, box_max_x, box_max_z, box_height, cell_index, zero pad
	input  logic [127:0]                  s_axis_tdata,
	// req_type
	input  logic [bhr_pkg::REQ_W-1:0]     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// cell_height
	output logic [bhr_pkg::HEIGHT_W-1:0]  m_axis_tdata,
	// texture_enable
	output logic                          m_axis_tuser,
	input  logic                          cfg_we,
	input  logic [bhr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bhr_pkg::COORD_W-1:0]   cfg_data
);

	bhr_pkg::region_t region_q;
	logic q_empty;
	logic q_pop;
	logic hold;
	bhr_pkg::cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q.min_x <= '0;
			region_q.min_z <= '0;
			region_q.max_x <= bhr_pkg::COORD_W'(256);
			region_q.max_z <= bhr_pkg::COORD_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				bhr_pkg::CFG_MIN_X: region_q.min_x <= cfg_data;
				bhr_pkg::CFG_MIN_Z: region_q.min_z <= cfg_data;
				bhr_pkg::CFG_MAX_X: region_q.max_x <= cfg_data;
				bhr_pkg::CFG_MAX_Z: region_q.max_z <= cfg_data;
				default: ;
			endcase
		end
	end

	bhr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.region(region_q),
		.hold(hold),
		.pop(q_pop),
		.empty(q_empty),
		.head(q_head)
	);

	bhr_back #(
		.GRID_RES(GRID_RES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.region(region_q),
		.empty(q_empty),
		.head(q_head),
		.pop(q_pop),
		.hold(hold),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

endmodule

/* dv/tb_box_height_rasterizer_unit.sv */
// Testbench of the box height rasterizer: directed table, random requests and a grid predictor.
`timescale 1ns / 100ps

module tb_box_height_rasterizer_unit;

	localparam int RES = 64;
	localparam int CELLS = RES * RES;
	localparam int STALL_LIMIT = 200000;
	localparam logic [bhr_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [bhr_pkg::REQ_W-1:0] kind;
		logic signed [23:0] bx0, bz0, bx1, bz1;
		logic [15:0] height;
		logic [11:0] cell_idx;
		bit known;
		logic [15:0] exp_height;
		logic exp_tex;
	} req_row_t;

	typedef struct {
		logic [15:0] height;
		logic tex;
	} cell_read_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic [bhr_pkg::REQ_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 0;
	logic [bhr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	box_height_rasterizer_unit dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Predictor state.
	longint reg_min_x, reg_min_z, reg_max_x, reg_max_z;
	logic [15:0] grid_height [CELLS];
	bit grid_covered [CELLS];
	cell_read_t pending_reads[$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 0;
	int quiet_cycles = 0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d != 0 && n < 0) q--;
		return q;
	endfunction

	function automatic longint ceil_div(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d != 0 && n > 0) q++;
		return q;
	endfunction

	function automatic longint clamp_cell(longint v);
		return v < 0 ? 0 : (v > RES - 1 ? RES - 1 : v);
	endfunction

	task automatic map_axis(input longint bmin, input longint bmax, input longint rmin,
			input longint span, output longint lo, output longint hi);
		longint a, b;
		a = ceil_div((bmin - rmin) * (RES - 1), span);
		b = floor_div((bmax - rmin) * (RES - 1), span);
		if (a > b) a = b;
		lo = clamp_cell(a);
		hi = clamp_cell(b);
	endtask

	task automatic predict_request(input req_row_t r);
		longint sx, sz, i0, i1, j0, j1;
		cell_read_t rd;
		case (r.kind)
			bhr_pkg::REQ_DRAW: begin
				sx = reg_max_x - reg_min_x;
				sz = reg_max_z - reg_min_z;
				if (sx > 0 && sz > 0 && r.bx0 <= reg_max_x && r.bx1 >= reg_min_x
						&& r.bz0 <= reg_max_z && r.bz1 >= reg_min_z) begin
					map_axis(r.bx0, r.bx1, reg_min_x, sx, i0, i1);
					map_axis(r.bz0, r.bz1, reg_min_z, sz, j0, j1);
					for (longint j = j0; j <= j1; j++)
						for (longint i = i0; i <= i1; i++) begin
							grid_height[j * RES + i] = r.height;
							grid_covered[j * RES + i] = 1;
						end
				end
			end
			bhr_pkg::REQ_READ: begin
				if (r.cell_idx < CELLS && grid_covered[r.cell_idx]) begin
					rd.height = grid_height[r.cell_idx];
					rd.tex = 0;
				end else begin
					rd.height = '0;
					rd.tex = 1;
				end
				if (r.known && (rd.height !== r.exp_height || rd.tex !== r.exp_tex))
					report_mismatch("directed row", {rd.height, rd.tex},
						{r.exp_height, r.exp_tex});
				pending_reads = {pending_reads, rd};
			end
			bhr_pkg::REQ_CLEAR: begin
				foreach (grid_covered[k]) grid_covered[k] = 0;
			end
			default: ;
		endcase
	endtask

	// Result checking and receiver stalls.
	always @(posedge clk) begin
		cell_read_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_reads.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata, 0);
				end else begin
					want = pending_reads.pop_front();
					if (m_axis_tdata !== want.height)
						report_mismatch("cell_height", $signed(m_axis_tdata),
							$signed(want.height));
					if (m_axis_tuser !== want.tex)
						report_mismatch("texture_enable", m_axis_tuser, want.tex);
				end
			end
			m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_region(input logic [bhr_pkg::CFG_IDX_W-1:0] idx, input longint v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v[23:0];
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			bhr_pkg::CFG_MIN_X: reg_min_x = v;
			bhr_pkg::CFG_MIN_Z: reg_min_z = v;
			bhr_pkg::CFG_MAX_X: reg_max_x = v;
			default: reg_max_z = v;
		endcase
	endtask

	task automatic set_region(input longint x0, input longint z0, input longint x1,
			input longint z1);
		write_region(bhr_pkg::CFG_MIN_X, x0);
		write_region(bhr_pkg::CFG_MIN_Z, z0);
		write_region(bhr_pkg::CFG_MAX_X, x1);
		write_region(bhr_pkg::CFG_MAX_Z, z1);
	endtask

	// Drives one request until it is accepted, then updates the predictor.
	task automatic send_request(input req_row_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= r.kind;
		s_axis_tdata <= {20'd0, r.cell_idx, r.height, r.bz1, r.bx1, r.bz0, r.bx0};
		do @(posedge clk); while (!s_axis_tready);
		predict_request(r);
	endtask

	// Waits out every pending read plus a full queue of the longest draws or clears.
	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat ((bhr_pkg::QUEUE_DEPTH + 2) * (CELLS + 200)) @(posedge clk);
	endtask

	function automatic req_row_t random_request(longint span);
		req_row_t r;
		int pick;
		longint a, b;
		r.known = 0;
		r.exp_height = '0;
		r.exp_tex = 0;
		r.height = 16'($urandom());
		r.cell_idx = 12'($urandom());
		r.bx0 = 24'($urandom());
		r.bz0 = 24'($urandom());
		r.bx1 = 24'($urandom());
		r.bz1 = 24'($urandom());
		pick = $urandom_range(99);
		if (pick < 40) begin
			r.kind = bhr_pkg::REQ_DRAW;
			if ($urandom_range(9) < 8) begin
				// Mostly boxes of a few cells around the region.
				a = reg_min_x - span / 8 + $urandom_range(32'(span + span / 4));
				b = reg_min_z - span / 8 + $urandom_range(32'(span + span / 4));
				r.bx0 = a[23:0];
				r.bz0 = b[23:0];
				a = a + $urandom_range(32'(span / 6)) - span / 40;
				b = b + $urandom_range(32'(span / 6)) - span / 40;
				r.bx1 = a[23:0];
				r.bz1 = b[23:0];
			end
		end else if (pick < 96) begin
			r.kind = bhr_pkg::REQ_READ;
			if ($urandom_range(9) == 0) r.cell_idx = 12'($urandom_range(4095, CELLS - 1));
		end else if (pick < 98) begin
			r.kind = bhr_pkg::REQ_CLEAR;
		end else begin
			r.kind = REQ_UNUSED;
		end
		return r;
	endfunction

	function automatic req_row_t row(logic [bhr_pkg::REQ_W-1:0] k, longint x0, longint z0,
			longint x1, longint z1, logic [15:0] h, logic [11:0] c,
			bit known = 0, logic [15:0] eh = 0, logic et = 0);
		req_row_t r;
		r.kind = k;
		r.bx0 = x0[23:0];
		r.bz0 = z0[23:0];
		r.bx1 = x1[23:0];
		r.bz1 = z1[23:0];
		r.height = h;
		r.cell_idx = c;
		r.known = known;
		r.exp_height = eh;
		r.exp_tex = et;
		return r;
	endfunction

	initial begin
		req_row_t directed[$];
		longint spans[4];
		int phase_idle[4];
		int phase_stall[4];
		int n;
		reg_min_x = 0;
		reg_min_z = 0;
		reg_max_x = 256;
		reg_max_z = 256;
		foreach (grid_covered[k]) begin
			grid_covered[k] = 0;
			grid_height[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;

		// Directed part at the reset region of 0 .. 256.
		directed = {
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 16'h1234, 0, 1, 0, 1),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'hFFF, 1, 0, 1),
			row(bhr_pkg::REQ_DRAW, 0, 0, 256, 256, 16'h7FFF, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 1, 16'h7FFF, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'hFFF, 1, 16'h7FFF, 0),
			row(bhr_pkg::REQ_DRAW, -8388608, -8388608, 8388607, 8388607, 16'h8000, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd2080, 1, 16'h8000, 0),
			row(bhr_pkg::REQ_DRAW, 300, 0, 400, 256, 16'h0101, 0),
			row(bhr_pkg::REQ_DRAW, 0, -50, 256, -1, 16'h0202, 0),
			row(bhr_pkg::REQ_DRAW, 200, 200, 50, 50, 16'h0303, 0),
			row(bhr_pkg::REQ_DRAW, 256, 256, 256, 256, 16'h0404, 0),
			row(bhr_pkg::REQ_DRAW, 3, 3, 5, 5, 16'h0505, 0),
			row(REQ_UNUSED, 0, 0, 256, 256, 16'h0606, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd2000, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd4095, 1, 16'h0404, 0),
			row(bhr_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd5, 1, 0, 1),
			row(bhr_pkg::REQ_DRAW, 0, 0, 128, 128, 16'hFFFF, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd0, 1, 16'hFFFF, 0),
			row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd4032, 0)
		};
		foreach (directed[i]) send_request(directed[i]);
		drain();

		// An empty region makes draws do nothing.
		set_region(100, 100, 100, 50);
		send_request(row(bhr_pkg::REQ_DRAW, -8388608, -8388608, 8388607, 8388607,
			16'h0777, 0));
		send_request(row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0, 12'd1000, 1, 0, 1));
		drain();

		spans[0] = 256;
		spans[1] = 16777215;
		spans[2] = 6000;
		spans[3] = 1;
		phase_idle = '{0, 51, 0, 28};
		phase_stall = '{0, 0, 51, 28};
		for (int p = 0; p < 4; p++) begin
			if (p == 1) set_region(-8388608, -8388608, 8388607, 8388607);
			else if (p == 3) set_region(8388606, -100, 8388607, -99);
			else set_region(-3000 + p, 1000, 3000 + p, 7000);
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			n = 0;
			while (n < 300) begin
				send_request(random_request(spans[p]));
				n++;
			end
			drain();
		end

		// Long receiver hold-off while reads keep coming, to fill the request queue.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++)
				send_request(row(bhr_pkg::REQ_READ, 0, 0, 0, 0, 0,
					12'($urandom_range(4095))));
		join
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
